>>> src/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
`default_nettype none

package iida_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;
  localparam int OP_W         = 2;

  localparam logic [CNT_W-1:0] CAPACITY_RST = 5'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_READ,
    S_FIN,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rd_pos;
    logic fin;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic go_move;
    logic go_read;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> src/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+-----------
//   in      | in_valid/in_stall, op, position, value | request in
//   out     | out_valid/out_stall, accepted, count,  | result out
//           | read_value                             |
//   cfg     | cfg_we, cfg_wdata (capacity in use)    | write only
//
// One request at a time. Insert/delete run a shift pass over the entries behind the
// position, moving one word per cycle through the slot RAM's single read and write
// port; reads and rejected requests skip it.
// Reset (synchronous, active low) clears the count; slot contents are not cleared.
// A stalled result waits in the output register; the next request is taken
// as soon as the result is loaded there.
`default_nettype none

module indexed_insert_delete_array #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [iida_pkg::CNT_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [iida_pkg::OP_W-1:0]          in_op,
  input  wire logic [iida_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [iida_pkg::DATA_W-1:0] in_item_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_accepted,
  output logic [iida_pkg::CNT_W-1:0]              out_entry_count,
  output logic signed [iida_pkg::DATA_W-1:0]      out_read_value
);

  iida_pkg::ctl_cmd_t cmd;
  iida_pkg::dp_sts_t  sts;

  iida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iida_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

>>> src/iida_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module iida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/iida_ctrl.sv
// Controller state machine: sequences accept, shift pass, read, finish and output.
`default_nettype none

module iida_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire iida_pkg::dp_sts_t  sts,
  output iida_pkg::ctl_cmd_t      cmd
);

  iida_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iida_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      iida_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.go_move) begin
            state_nxt = iida_pkg::S_MOVE;
          end else if (sts.go_read) begin
            state_nxt = iida_pkg::S_READ;
          end else begin
            state_nxt = iida_pkg::S_FIN;
          end
        end
      end
      iida_pkg::S_MOVE: begin
        cmd.step = sts.more;
        if (!sts.more) begin
          state_nxt = iida_pkg::S_FIN;
        end
      end
      iida_pkg::S_READ: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = iida_pkg::S_FIN;
      end
      iida_pkg::S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = iida_pkg::S_OUT;
      end
      iida_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = iida_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = iida_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/iida_dp.sv
// Datapath: capacity register, count, slot RAM, shift pointers and result registers.
`default_nettype none

module iida_dp #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [iida_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire logic [iida_pkg::OP_W-1:0]         in_op,
  input  wire logic [iida_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [iida_pkg::DATA_W-1:0] in_item_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_accepted,
  output logic [iida_pkg::CNT_W-1:0]             out_entry_count,
  output logic signed [iida_pkg::DATA_W-1:0]    out_read_value,
  input  wire iida_pkg::ctl_cmd_t                cmd,
  output iida_pkg::dp_sts_t                      sts
);

  localparam int CW = iida_pkg::CNT_W;
  localparam int DW = iida_pkg::DATA_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CAP_CLAMP = (CAPACITY > 31) ? 31 : CAPACITY;
  localparam logic [CW-1:0] CAP_LIM = CW'(CAP_CLAMP);

  logic [CW-1:0]                capacity_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [iida_pkg::OP_W-1:0]    op_r;
  logic [iida_pkg::POS_W-1:0]   pos_r;
  logic [DW-1:0]                val_r;
  logic                         ok_r;
  logic [CW-1:0]                ptr_r;
  logic [CW-1:0]                mv_r;
  logic [CW-1:0]                wa_r;
  logic                         wpend_r;
  logic                         res_acc_r;
  logic [CW-1:0]                res_cnt_r;
  logic [DW-1:0]                res_val_r;
  logic                         out_valid_r;

  logic [CW-1:0] limit;
  logic [CW-1:0] pos5;
  logic          ld_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign limit = (capacity_r > CAP_LIM) ? CAP_LIM : capacity_r;
  assign pos5  = {1'b0, in_position};

  always_comb begin
    ld_ok = 1'b0;
    case (in_op)
      iida_pkg::OP_INSERT: ld_ok = (pos5 <= count_r) && (count_r < limit);
      iida_pkg::OP_DELETE: ld_ok = pos5 < count_r;
      iida_pkg::OP_READ:   ld_ok = pos5 < count_r;
      default:             ld_ok = 1'b0;
    endcase
  end

  assign sts.go_move  = ld_ok && ((in_op == iida_pkg::OP_INSERT) ||
                                  (in_op == iida_pkg::OP_DELETE));
  assign sts.go_read  = ld_ok && (in_op == iida_pkg::OP_READ);
  assign sts.more     = mv_r != '0;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt = count_r;
    if (cmd.fin && ok_r) begin
      if (op_r == iida_pkg::OP_INSERT) begin
        count_nxt = count_r + 1'b1;
      end else if (op_r == iida_pkg::OP_DELETE) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  // Shift moves write the word read in the previous cycle; insert writes its value last.
  assign ram_we    = wpend_r || (cmd.fin && ok_r && (op_r == iida_pkg::OP_INSERT));
  assign ram_waddr = wpend_r ? AW'(wa_r) : AW'(pos_r);
  assign ram_wdata = wpend_r ? ram_rdata : val_r;
  assign ram_raddr = cmd.rd_pos ? AW'(pos_r) : AW'(ptr_r);

  iida_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= iida_pkg::CAPACITY_RST;
      count_r     <= '0;
      mv_r        <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      wpend_r     <= cmd.step;
      out_valid_r <= cmd.out_load || (out_valid_r && out_stall);
      if (cmd.load) begin
        if (in_op == iida_pkg::OP_INSERT) begin
          mv_r <= count_r - pos5;
        end else begin
          mv_r <= count_r - pos5 - 1'b1;
        end
      end else if (cmd.step) begin
        mv_r <= mv_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= in_position;
      val_r <= in_item_value;
      ok_r  <= ld_ok;
      if (in_op == iida_pkg::OP_INSERT) begin
        ptr_r <= count_r - 1'b1;
      end else begin
        ptr_r <= pos5 + 1'b1;
      end
    end else if (cmd.step) begin
      if (op_r == iida_pkg::OP_INSERT) begin
        wa_r  <= ptr_r + 1'b1;
        ptr_r <= ptr_r - 1'b1;
      end else begin
        wa_r  <= ptr_r - 1'b1;
        ptr_r <= ptr_r + 1'b1;
      end
    end
    if (cmd.fin) begin
      res_acc_r <= ok_r;
      res_cnt_r <= count_nxt;
      res_val_r <= (ok_r && (op_r == iida_pkg::OP_READ)) ? ram_rdata : '0;
    end
    if (cmd.out_load) begin
      out_accepted    <= res_acc_r;
      out_entry_count <= res_cnt_r;
      out_read_value  <= res_val_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> test/indexed_insert_delete_array_test.sv
// Self-checking testbench for the indexed insert/delete array: shift-array predictor and scoreboard.
`timescale 1ns / 1ps

class array_scoreboard;
  typedef struct packed {
    logic                                accepted;
    logic [iida_pkg::CNT_W-1:0]          count;
    logic signed [iida_pkg::DATA_W-1:0]  value;
  } array_result_t;

  logic signed [iida_pkg::DATA_W-1:0] slots [iida_pkg::CAPACITY_DEF];
  int unsigned                        used;
  logic [iida_pkg::CNT_W-1:0]         capacity;
  array_result_t                      expected_q [$];
  int errors;
  int n_insert, n_delete, n_read, n_reject, peak, full_hits;

  function new();
    used = 0;
    capacity = iida_pkg::CAPACITY_RST;
    errors = 0;
    n_insert = 0;
    n_delete = 0;
    n_read = 0;
    n_reject = 0;
    peak = 0;
    full_hits = 0;
  endfunction

  function int unsigned limit();
    return (capacity > iida_pkg::CAPACITY_DEF) ? iida_pkg::CAPACITY_DEF : capacity;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void set_capacity(logic [iida_pkg::CNT_W-1:0] cap);
    capacity = cap;
  endfunction

  function void note_request(logic [iida_pkg::OP_W-1:0] op, logic [iida_pkg::POS_W-1:0] pos,
                             logic signed [iida_pkg::DATA_W-1:0] val);
    array_result_t r;
    int unsigned i;
    r = '0;
    case (op)
      iida_pkg::OP_INSERT: begin
        if (pos <= used && used < limit()) begin
          for (i = used; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = val;
          used++;
          r.accepted = 1'b1;
          n_insert++;
          if (used > peak) peak = used;
          if (used == limit()) full_hits++;
        end
      end
      iida_pkg::OP_DELETE: begin
        if (pos < used) begin
          for (i = pos; i + 1 < used; i++) slots[i] = slots[i+1];
          used--;
          r.accepted = 1'b1;
          n_delete++;
        end
      end
      iida_pkg::OP_READ: begin
        if (pos < used) begin
          r.value = slots[pos];
          r.accepted = 1'b1;
          n_read++;
        end
      end
      default: ;
    endcase
    if (!r.accepted) n_reject++;
    r.count = used[iida_pkg::CNT_W-1:0];
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(logic acc, logic [iida_pkg::CNT_W-1:0] cnt,
                    logic signed [iida_pkg::DATA_W-1:0] rd);
    array_result_t r;
    if (expected_q.size() == 0) begin
      report($sformatf("result with no request pending (acc %0b count %0d value %0h)",
                       acc, cnt, rd));
      return;
    end
    r = expected_q.pop_front();
    if (acc !== r.accepted)
      report($sformatf("accepted got %0b expected %0b", acc, r.accepted));
    if (cnt !== r.count)
      report($sformatf("entry_count got %0d expected %0d", cnt, r.count));
    if (rd !== r.value)
      report($sformatf("read_value got %0h expected %0h", rd, r.value));
  endtask
endclass

module indexed_insert_delete_array_test;

  localparam logic [iida_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int SEGMENT_ITEMS = 135;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [iida_pkg::CNT_W-1:0]         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [iida_pkg::OP_W-1:0]          in_op = '0;
  logic [iida_pkg::POS_W-1:0]         in_position = '0;
  logic signed [iida_pkg::DATA_W-1:0] in_item_value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_accepted;
  logic [iida_pkg::CNT_W-1:0]         out_entry_count;
  logic signed [iida_pkg::DATA_W-1:0] out_read_value;

  int gap_pct = 0;
  int stall_pct = 0;
  int n_settings = 1;
  bit filling = 1'b1;
  array_scoreboard sb = new();

  indexed_insert_delete_array dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_position(in_position),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_entry_count(out_entry_count),
    .out_read_value(out_read_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_accepted, out_entry_count, out_read_value);
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  task send_request(logic [iida_pkg::OP_W-1:0] op, logic [iida_pkg::POS_W-1:0] pos,
                    logic signed [iida_pkg::DATA_W-1:0] val);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_position <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, pos, val);
  endtask

  task drain_requests();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_capacity(logic [iida_pkg::CNT_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(cap);
    n_settings++;
  endtask

  task random_request();
    int unsigned cnt;
    int unsigned lim;
    int w;
    int k;
    logic [iida_pkg::OP_W-1:0] op;
    logic [iida_pkg::POS_W-1:0] pos;
    logic signed [iida_pkg::DATA_W-1:0] val;
    cnt = sb.used;
    lim = sb.limit();
    if (cnt == 0) filling = 1'b1;
    else if (cnt >= lim) filling = 1'b0;
    else if ($urandom_range(0, 99) < 4) filling = !filling;
    if ($urandom_range(0, 99) < 6) begin
      op = iida_pkg::OP_W'($urandom_range(0, 3));
      pos = iida_pkg::POS_W'($urandom_range(0, 15));
    end else begin
      w = $urandom_range(0, 99);
      if (filling) begin
        op = (w < 60) ? iida_pkg::OP_INSERT : (w < 85) ? iida_pkg::OP_READ : iida_pkg::OP_DELETE;
      end else begin
        op = (w < 55) ? iida_pkg::OP_DELETE : (w < 80) ? iida_pkg::OP_READ : iida_pkg::OP_INSERT;
      end
      if (op == iida_pkg::OP_INSERT)
        pos = iida_pkg::POS_W'($urandom_range(0, (cnt > 15) ? 15 : cnt));
      else if (cnt == 0) pos = iida_pkg::POS_W'($urandom_range(0, 15));
      else pos = iida_pkg::POS_W'($urandom_range(0, cnt - 1));
    end
    k = $urandom_range(0, 9);
    case (k)
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = ($urandom_range(0, 1) != 0) ? 32'sh0 : -32'sd1;
      default: val = $urandom;
    endcase
    send_request(op, pos, val);
  endtask

  initial begin
    int phase_gap [3];
    int phase_stall [3];
    logic [iida_pkg::CNT_W-1:0] caps [12];
    int p;
    int s;
    int n;
    phase_gap = '{31, 62, 0};
    phase_stall = '{62, 31, 0};
    caps = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd16, 5'd9, 5'd31, 5'd2, 5'd16, 5'd0, 5'd12};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = phase_gap[0];
    stall_pct = phase_stall[0];

    // empty array, pos == count, unused op, extremes of value, shifts at ends and middle
    send_request(iida_pkg::OP_READ, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_DELETE, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_INSERT, 4'd1, 32'sd9);
    send_request(OP_UNUSED, 4'd15, -32'sd1);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sh8000_0000);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sh7fff_ffff);
    send_request(iida_pkg::OP_INSERT, 4'd2, -32'sd1);
    send_request(iida_pkg::OP_INSERT, 4'd1, 32'sd0);
    send_request(iida_pkg::OP_READ, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_READ, 4'd3, 32'sd0);
    send_request(iida_pkg::OP_READ, 4'd4, 32'sd0);
    send_request(iida_pkg::OP_DELETE, 4'd4, 32'sd0);
    send_request(iida_pkg::OP_DELETE, 4'd3, 32'sd0);
    send_request(iida_pkg::OP_DELETE, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_READ, 4'd1, 32'sd0);
    drain_requests();
    // capacity below current count
    write_capacity(5'd1);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sd5);
    send_request(iida_pkg::OP_READ, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_DELETE, 4'd1, 32'sd0);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sd6);
    drain_requests();
    write_capacity(5'd0);
    send_request(iida_pkg::OP_DELETE, 4'd0, 32'sd0);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sd1);
    drain_requests();
    write_capacity(5'd31);
    send_request(iida_pkg::OP_INSERT, 4'd0, 32'sh5555_aaaa);
    send_request(iida_pkg::OP_READ, 4'd15, 32'sd0);
    send_request(iida_pkg::OP_READ, 4'd0, 32'sd0);
    drain_requests();

    for (p = 0; p < 3; p++) begin
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      for (s = 0; s < 4; s++) begin
        write_capacity(caps[p*4 + s]);
        for (n = 0; n < SEGMENT_ITEMS; n++) random_request();
        drain_requests();
      end
    end

    $display("covered %0d inserts, %0d deletes, %0d reads accepted and %0d rejected requests",
             sb.n_insert, sb.n_delete, sb.n_read, sb.n_reject);
    $display("array reached its limit %0d times over %0d capacity settings, peak count %0d",
             sb.full_hits, n_settings, sb.peak);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("FAIL");
    $finish;
  end
endmodule

>>> indexed_insert_delete_array.f
src/iida_pkg.sv
src/iida_ram.sv
src/iida_ctrl.sv
src/iida_dp.sv
src/indexed_insert_delete_array.sv
test/indexed_insert_delete_array_test.sv
